// ===== hw/rtl/i2c_master_transaction_sequencer_macros.svh =====
// Assertion macros shared by the sequencer's checker.
// Depends on nothing; expects clk and rst_n in the scope of use.
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_MACROS_SVH

// Checked outside reset only.
`define I2CS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define I2CS_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/i2cs_pkg.sv =====
// Types and constants of the I2C master transaction sequencer.
// Depends on nothing; used by i2cs_core, the top level, the checker and the bench.
`timescale 1ns / 1ps

package i2cs_pkg;

  // Item kinds carried on in_tuser
  localparam logic [1:0] MODE_BEGIN = 2'd0;
  localparam logic [1:0] MODE_PUSH  = 2'd1;
  localparam logic [1:0] MODE_EVENT = 2'd2;
  localparam logic [1:0] MODE_ERROR = 2'd3;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;

  // Result field positions in out_tdata
  localparam int OB_DR_WRITE   = 0;
  localparam int OB_DR_VALUE   = 1;
  localparam int OB_GEN_START  = 9;
  localparam int OB_GEN_STOP   = 10;
  localparam int OB_ACK_SET    = 11;
  localparam int OB_ACK_CLEAR  = 12;
  localparam int OB_BUF_IRQ    = 13;
  localparam int OB_RX_VALID   = 14;
  localparam int OB_RX_VALUE   = 15;
  localparam int OB_FINISHED   = 23;
  localparam int OB_BUSY_RES   = 24;
  localparam int OB_WRITE_DONE = 25;
  localparam int OUT_USED_W    = 26;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] dev_addr;
    logic [4:0] send_len;
    logic [4:0] recv_len;
    logic [7:0] data_byte;
    logic       flag_start;
    logic       flag_addr;
    logic       flag_byte_done;
    logic       flag_tx_empty;
    logic       flag_rx_ready;
  } item_t;

  typedef struct packed {
    logic       dr_write;
    logic [7:0] dr_value;
    logic       gen_start;
    logic       gen_stop;
    logic       ack_set;
    logic       ack_clear;
    logic       buf_irq_enable;
    logic       rx_valid;
    logic [7:0] rx_value;
    logic       finished;
    logic       busy_res;
    logic       write_done;
  } res_t;

endpackage

// ===== hw/rtl/i2cs_wstore.sv =====
// Write byte store: one write port, one registered read port with bypass.
// Depends on nothing; instantiated by i2cs_core.
`timescale 1ns / 1ps

module i2cs_wstore #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // rdata is registered from raddr's entry, with a same-address write passed through
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/i2cs_core.sv =====
// Command state and per-item decision logic of the sequencer.
// Depends on i2cs_pkg and i2cs_wstore.
`timescale 1ns / 1ps

module i2cs_core import i2cs_pkg::*; #(
  parameter int MAX_BYTES = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  item_t item,
  output res_t  res
);

  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int LW = (CW > 5) ? CW : 5;

  logic [CW-1:0] wt_r, wt_nxt, wc_r, wc_nxt, rt_r, rt_nxt, rc_r, rc_nxt;
  logic [CW-1:0] pc_r, pc_nxt;
  logic [6:0]    addr_r, addr_nxt;
  logic          addr_done_r, addr_done_nxt;
  logic          busy_r, busy_nxt;
  logic          have_r, have_nxt;
  logic          irq_r, irq_nxt;

  logic          mem_we;
  logic [7:0]    mem_rdata;
  logic [CW:0]   wc_inc, rc_inc;
  logic [LW-1:0] send_ext, recv_ext, max_ext;

  i2cs_wstore #(
    .DEPTH (MAX_BYTES),
    .AW    (AW)
  ) u_wstore (
    .clk   (clk),
    .we    (mem_we),
    .waddr (pc_r[AW-1:0]),
    .wdata (item.data_byte),
    .raddr (wc_nxt[AW-1:0]),
    .rdata (mem_rdata)
  );

  assign wc_inc   = {1'b0, wc_r} + (CW+1)'(1);
  assign rc_inc   = {1'b0, rc_r} + (CW+1)'(1);
  assign send_ext = LW'(item.send_len);
  assign recv_ext = LW'(item.recv_len);
  assign max_ext  = LW'(MAX_BYTES);

  always_comb begin
    wt_nxt        = wt_r;
    wc_nxt        = wc_r;
    rt_nxt        = rt_r;
    rc_nxt        = rc_r;
    pc_nxt        = pc_r;
    addr_nxt      = addr_r;
    addr_done_nxt = addr_done_r;
    busy_nxt      = busy_r;
    have_nxt      = have_r;
    irq_nxt       = irq_r;
    mem_we        = 1'b0;
    res           = '0;

    if (adv) begin
      case (item.mode)
        MODE_BEGIN: begin
          if (!busy_r) begin
            addr_nxt      = item.dev_addr;
            wt_nxt        = (send_ext > max_ext) ? CW'(max_ext) : CW'(send_ext);
            rt_nxt        = (recv_ext > max_ext) ? CW'(max_ext) : CW'(recv_ext);
            wc_nxt        = '0;
            rc_nxt        = '0;
            pc_nxt        = '0;
            addr_done_nxt = 1'b0;
            have_nxt      = 1'b1;
            busy_nxt      = 1'b1;
            res.gen_start = 1'b1;
          end
        end
        MODE_PUSH: begin
          if (have_r && (pc_r < wt_r)) begin
            mem_we = 1'b1;
            pc_nxt = pc_r + CW'(1);
          end
        end
        MODE_EVENT: begin
          if (!have_r) begin
            busy_nxt = 1'b0;
          end else if (item.flag_start) begin
            if (wc_r == wt_r) begin
              // all bytes written: start for the read half went out, address for read
              res.dr_write = 1'b1;
              res.dr_value = {addr_r, 1'b1};
              res.ack_set  = 1'b1;
            end else if (!addr_done_r) begin
              addr_done_nxt = 1'b1;
              res.dr_write  = 1'b1;
              res.dr_value  = {addr_r, 1'b0};
            end
          end else if (item.flag_addr) begin
            if (wc_r == wt_r) begin
              irq_nxt = 1'b1;
            end else if (wc_r < wt_r) begin
              res.dr_write = 1'b1;
              res.dr_value = mem_rdata;
              wc_nxt       = CW'(wc_inc);
              irq_nxt      = (wc_inc != {1'b0, wt_r});
            end
          end else if (item.flag_byte_done) begin
            if (rt_r == '0) begin
              have_nxt       = 1'b0;
              busy_nxt       = 1'b0;
              res.finished   = 1'b1;
              res.gen_stop   = 1'b1;
              res.write_done = 1'b1;
            end else begin
              res.gen_start = 1'b1;
            end
          end else if (item.flag_tx_empty) begin
            if (wc_r < wt_r) begin
              res.dr_write = 1'b1;
              res.dr_value = mem_rdata;
              wc_nxt       = CW'(wc_inc);
              if (wc_inc == {1'b0, wt_r}) begin
                irq_nxt = 1'b0;
              end
            end
          end else if (item.flag_rx_ready) begin
            if (rc_inc < {1'b0, rt_r}) begin
              res.rx_valid = 1'b1;
              res.rx_value = item.data_byte;
              rc_nxt       = CW'(rc_inc);
            end else if (rc_r < rt_r) begin
              // second to last byte: NACK the last one and stop
              rc_nxt        = CW'(rc_inc);
              res.ack_clear = 1'b1;
              res.gen_stop  = 1'b1;
            end else begin
              res.rx_valid = 1'b1;
              res.rx_value = item.data_byte;
              irq_nxt      = 1'b0;
              have_nxt     = 1'b0;
              busy_nxt     = 1'b0;
              res.finished = 1'b1;
            end
          end
        end
        MODE_ERROR: begin
          busy_nxt = 1'b0;
          if (have_r) begin
            have_nxt     = 1'b0;
            res.finished = 1'b1;
          end
        end
        default: begin
          busy_nxt = busy_r;
        end
      endcase
    end

    res.buf_irq_enable = irq_nxt;
    res.busy_res       = busy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wt_r        <= '0;
      wc_r        <= '0;
      rt_r        <= '0;
      rc_r        <= '0;
      pc_r        <= '0;
      addr_r      <= '0;
      addr_done_r <= 1'b0;
      busy_r      <= 1'b0;
      have_r      <= 1'b0;
      irq_r       <= 1'b0;
    end else begin
      wt_r        <= wt_nxt;
      wc_r        <= wc_nxt;
      rt_r        <= rt_nxt;
      rc_r        <= rc_nxt;
      pc_r        <= pc_nxt;
      addr_r      <= addr_nxt;
      addr_done_r <= addr_done_nxt;
      busy_r      <= busy_nxt;
      have_r      <= have_nxt;
      irq_r       <= irq_nxt;
    end
  end

endmodule

// ===== hw/rtl/i2c_master_transaction_sequencer.sv =====
// Top level of the I2C master write-then-read transaction sequencer.
// Depends on i2cs_pkg and i2cs_core (which holds i2cs_wstore).
//
//   port group  direction  carries
//   in_*        slave      command, write bytes, peripheral events, bus errors
//   out_*       master     one result item per input item
//
// Cycles: one item per clock sustained while out_tready is high; an item's result
//   goes through the input register, then the result register, to out_*.
// The decision logic sits between those two registers; the write store's
//   read port is prefetched at the next write index, so its read is ready in time.
// Reset: rst_n low for one clock clears all command state; no clearing pass.
// Stalls: out_tready low holds the result; one more item waits in the input
//   register, then in_tready drops.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer import i2cs_pkg::*; #(
  parameter int MAX_BYTES = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [6:0] dev_addr, [11:7] send_len, [16:12] recv_len, [24:17] data_byte,
  // [25] flag_start, [26] flag_addr, [27] flag_byte_done,
  // [28] flag_tx_empty, [29] flag_rx_ready, [31:30] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] mode
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] dr_write, [8:1] dr_value, [9] gen_start, [10] gen_stop,
  // [11] ack_set, [12] ack_clear, [13] buf_irq_enable, [14] rx_valid,
  // [22:15] rx_value, [23] finished, [24] busy_res, [25] write_done,
  // [31:26] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  item_t s1_item_r, in_item;
  logic  s1_valid_r, s1_valid_nxt;
  res_t  res_c, out_res_r;
  logic  out_valid_r, out_valid_nxt;
  logic  out_load, in_acc;

  // Unpack the input item
  assign in_item.mode           = in_tuser[1:0];
  assign in_item.dev_addr       = in_tdata[6:0];
  assign in_item.send_len       = in_tdata[11:7];
  assign in_item.recv_len       = in_tdata[16:12];
  assign in_item.data_byte      = in_tdata[24:17];
  assign in_item.flag_start     = in_tdata[25];
  assign in_item.flag_addr      = in_tdata[26];
  assign in_item.flag_byte_done = in_tdata[27];
  assign in_item.flag_tx_empty  = in_tdata[28];
  assign in_item.flag_rx_ready  = in_tdata[29];

  // Held item moves on whenever the result register is free or draining
  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;
  assign in_acc    = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (out_load ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  i2cs_core #(
    .MAX_BYTES (MAX_BYTES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (out_load),
    .item  (s1_item_r),
    .res   (res_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (out_load) begin
      out_res_r <= res_c;
    end
  end

  assign out_tvalid = out_valid_r;

  // Pack the result item
  assign out_tdata[OB_DR_WRITE]                = out_res_r.dr_write;
  assign out_tdata[OB_DR_VALUE+7:OB_DR_VALUE]  = out_res_r.dr_value;
  assign out_tdata[OB_GEN_START]               = out_res_r.gen_start;
  assign out_tdata[OB_GEN_STOP]                = out_res_r.gen_stop;
  assign out_tdata[OB_ACK_SET]                 = out_res_r.ack_set;
  assign out_tdata[OB_ACK_CLEAR]               = out_res_r.ack_clear;
  assign out_tdata[OB_BUF_IRQ]                 = out_res_r.buf_irq_enable;
  assign out_tdata[OB_RX_VALID]                = out_res_r.rx_valid;
  assign out_tdata[OB_RX_VALUE+7:OB_RX_VALUE]  = out_res_r.rx_value;
  assign out_tdata[OB_FINISHED]                = out_res_r.finished;
  assign out_tdata[OB_BUSY_RES]                = out_res_r.busy_res;
  assign out_tdata[OB_WRITE_DONE]              = out_res_r.write_done;
  assign out_tdata[OUT_TDATA_W-1:OUT_USED_W]   = '0;

endmodule

// ===== hw/rtl/i2cs_checker.sv =====
// Port-level checks of the sequencer, bound to the top level.
// Depends on i2cs_pkg and i2c_master_transaction_sequencer_macros.svh.
`timescale 1ns / 1ps
`include "i2c_master_transaction_sequencer_macros.svh"

module i2cs_checker import i2cs_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `I2CS_CHECK_RST(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")
  `I2CS_CHECK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `I2CS_CHECK(a_ready_when_empty, !out_tvalid |-> in_tready, "input stalled with empty result register")
  `I2CS_CHECK(a_finish_idle, out_tvalid && out_tdata[OB_FINISHED] |-> !out_tdata[OB_BUSY_RES], "finished item left bus busy")
  `I2CS_CHECK(a_write_done, out_tvalid && out_tdata[OB_WRITE_DONE] |-> out_tdata[OB_FINISHED] && out_tdata[OB_GEN_STOP], "write end without stop")

endmodule

bind i2c_master_transaction_sequencer i2cs_checker u_i2cs_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking bench for i2c_master_transaction_sequencer: directed and random
// commands, write bytes, bus events and errors, checked against a local predictor.
// Depends on i2cs_pkg and the sequencer RTL only.
`timescale 1ns / 1ps

module tb_top;
  import i2cs_pkg::*;

  localparam int STORE_DEPTH = 16;
  localparam int SW          = $clog2(STORE_DEPTH);
  localparam int NUM_ITEMS   = 550;
  localparam int NUM_FIELDS  = 12;
  localparam int MAX_REPORTS = 60;

  // Event flags by priority, highest first; also their bit index in the flag group
  localparam int EV_START     = 0;
  localparam int EV_ADDR      = 1;
  localparam int EV_BYTE_DONE = 2;
  localparam int EV_TX_EMPTY  = 3;
  localparam int EV_RX_READY  = 4;

  // Flow-control phases, one quarter of the run each
  localparam int PH_FREE       = 0;
  localparam int PH_SRC_IDLE   = 1;
  localparam int PH_SINK_STALL = 2;
  localparam int PH_BOTH       = 3;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  i2c_master_transaction_sequencer #(.MAX_BYTES(STORE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer shadow: command, counters and write bytes as the block sees them
  // ---------------------------------------------------------------------------
  logic [7:0] shadow_store [STORE_DEPTH];
  int         tx_total    = 0;
  int         tx_sent     = 0;
  int         rx_total    = 0;
  int         rx_taken    = 0;
  int         pushes_seen = 0;
  logic [6:0] target      = '0;
  logic       addr_sent   = 1'b0;
  logic       bus_busy    = 1'b0;
  logic       cmd_open    = 1'b0;
  logic       buf_irq     = 1'b0;

  function automatic int sat_len(logic [4:0] len);
    return (len > STORE_DEPTH) ? STORE_DEPTH : int'(len);
  endfunction

  // Applies one item to the shadow and returns the packed result word it causes
  function automatic logic [OUT_TDATA_W-1:0] sequencer_step(item_t it);
    res_t                   r;
    logic [OUT_TDATA_W-1:0] w;
    r = '0;
    w = '0;
    case (it.mode)
      MODE_BEGIN: begin
        // a begin on a busy bus is dropped
        if (!bus_busy) begin
          target      = it.dev_addr;
          tx_total    = sat_len(it.send_len);
          rx_total    = sat_len(it.recv_len);
          tx_sent     = 0;
          rx_taken    = 0;
          pushes_seen = 0;
          addr_sent   = 1'b0;
          cmd_open    = 1'b1;
          bus_busy    = 1'b1;
          r.gen_start = 1'b1;
        end
      end
      MODE_PUSH: begin
        if (cmd_open && pushes_seen < tx_total) begin
          shadow_store[SW'(pushes_seen)] = it.data_byte;
          pushes_seen++;
        end
      end
      MODE_EVENT: begin
        if (!cmd_open) begin
          bus_busy = 1'b0;
        end else if (it.flag_start) begin
          // all bytes written: address with read bit, else address with write bit once
          if (tx_sent == tx_total) begin
            r.dr_write = 1'b1;
            r.dr_value = {target, 1'b1};
            r.ack_set  = 1'b1;
          end else if (!addr_sent) begin
            addr_sent  = 1'b1;
            r.dr_write = 1'b1;
            r.dr_value = {target, 1'b0};
          end
        end else if (it.flag_addr) begin
          if (tx_sent == tx_total) begin
            buf_irq = 1'b1;
          end else begin
            r.dr_write = 1'b1;
            r.dr_value = shadow_store[SW'(tx_sent)];
            tx_sent++;
            buf_irq = (tx_sent != tx_total);
          end
        end else if (it.flag_byte_done) begin
          if (rx_total == 0) begin
            cmd_open     = 1'b0;
            bus_busy     = 1'b0;
            r.finished   = 1'b1;
            r.gen_stop   = 1'b1;
            r.write_done = 1'b1;
          end else begin
            r.gen_start = 1'b1;
          end
        end else if (it.flag_tx_empty) begin
          if (tx_sent < tx_total) begin
            r.dr_write = 1'b1;
            r.dr_value = shadow_store[SW'(tx_sent)];
            tx_sent++;
            if (tx_sent == tx_total) buf_irq = 1'b0;
          end
        end else if (it.flag_rx_ready) begin
          if (rx_taken + 1 < rx_total) begin
            r.rx_valid = 1'b1;
            r.rx_value = it.data_byte;
            rx_taken++;
          end else if (rx_taken < rx_total) begin
            // next to last byte: NACK the last one and queue STOP
            rx_taken++;
            r.ack_clear = 1'b1;
            r.gen_stop  = 1'b1;
          end else begin
            r.rx_valid = 1'b1;
            r.rx_value = it.data_byte;
            buf_irq    = 1'b0;
            cmd_open   = 1'b0;
            bus_busy   = 1'b0;
            r.finished = 1'b1;
          end
        end
      end
      MODE_ERROR: begin
        bus_busy = 1'b0;
        if (cmd_open) begin
          cmd_open   = 1'b0;
          r.finished = 1'b1;
        end
      end
    endcase
    r.buf_irq_enable = buf_irq;
    r.busy_res       = bus_busy;

    w[OB_DR_WRITE]        = r.dr_write;
    w[OB_DR_VALUE +: 8]   = r.dr_value;
    w[OB_GEN_START]       = r.gen_start;
    w[OB_GEN_STOP]        = r.gen_stop;
    w[OB_ACK_SET]         = r.ack_set;
    w[OB_ACK_CLEAR]       = r.ack_clear;
    w[OB_BUF_IRQ]         = r.buf_irq_enable;
    w[OB_RX_VALID]        = r.rx_valid;
    w[OB_RX_VALUE +: 8]   = r.rx_value;
    w[OB_FINISHED]        = r.finished;
    w[OB_BUSY_RES]        = r.busy_res;
    w[OB_WRITE_DONE]      = r.write_done;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  item_t                  pending_items[$];
  logic [OUT_TDATA_W-1:0] expected_words[$];
  int                     total_items = 1;

  function automatic item_t rand_item(logic [1:0] m);
    item_t      it;
    logic [4:0] fl;
    it.mode       = m;
    it.dev_addr   = 7'($urandom_range(0, 127));
    it.send_len   = 5'($urandom_range(0, 31));
    it.recv_len   = 5'($urandom_range(0, 31));
    it.data_byte  = 8'($urandom_range(0, 255));
    fl            = 5'($urandom_range(0, 31));
    {it.flag_rx_ready, it.flag_tx_empty, it.flag_byte_done, it.flag_addr, it.flag_start} = fl;
    return it;
  endfunction

  // Event whose handled flag is prio; lower-priority flags ride along at random
  function automatic item_t event_item(int prio);
    item_t      it;
    logic [4:0] fl;
    it = rand_item(MODE_EVENT);
    fl = 5'(($urandom & (31 << (prio + 1))) | (1 << prio));
    {it.flag_rx_ready, it.flag_tx_empty, it.flag_byte_done, it.flag_addr, it.flag_start} = fl;
    return it;
  endfunction

  // One well-formed command with random content; sometimes cut short by a bus
  // error, sometimes with stray items mixed in.
  task automatic queue_transfer(logic [4:0] wraw, logic [4:0] rraw);
    item_t seq[$];
    item_t it;
    int    nw;
    int    nr;
    int    cut;
    nw = sat_len(wraw);
    nr = sat_len(rraw);
    it = rand_item(MODE_BEGIN);
    it.send_len = wraw;
    it.recv_len = rraw;
    seq.push_back(it);
    repeat (nw) seq.push_back(rand_item(MODE_PUSH));
    seq.push_back(event_item(EV_START));
    if (nw > 0) begin
      seq.push_back(event_item(EV_ADDR));
      repeat (nw - 1) seq.push_back(event_item(EV_TX_EMPTY));
      seq.push_back(event_item(EV_BYTE_DONE));
    end
    if (nw == 0 || nr > 0) begin
      // repeated start for the read half when there was a write half
      if (nw > 0) seq.push_back(event_item(EV_START));
      seq.push_back(event_item(EV_ADDR));
      repeat (nr + 1) seq.push_back(event_item(EV_RX_READY));
    end
    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, seq.size()) : seq.size();
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 24) == 0)
        pending_items.push_back(rand_item(2'($urandom_range(0, 3))));
      pending_items.push_back(seq[i]);
    end
    if (cut < seq.size()) pending_items.push_back(rand_item(MODE_ERROR));
  endtask

  function automatic int idle_pct(int done, bit sink_side);
    int phase;
    phase = done * 4 / total_items;
    case (phase)
      PH_SRC_IDLE:   return sink_side ? 0 : 82;
      PH_SINK_STALL: return sink_side ? 82 : 0;
      PH_BOTH:       return 30;
      default:       return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one item per handshake, prediction taken at acceptance
  // ---------------------------------------------------------------------------
  item_t cur_item;
  int    items_sent   = 0;
  int    results_seen = 0;
  int    mismatches   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_words.push_back(sequencer_step(cur_item));
        items_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 &&
            $urandom_range(0, 99) >= idle_pct(items_sent, 1'b0)) begin
          cur_item = pending_items.pop_front();
          in_tdata <= {2'b00, cur_item.flag_rx_ready, cur_item.flag_tx_empty,
                       cur_item.flag_byte_done, cur_item.flag_addr, cur_item.flag_start,
                       cur_item.data_byte, cur_item.recv_len, cur_item.send_len,
                       cur_item.dev_addr};
          in_tuser  <= cur_item.mode;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each result against the oldest expectation, per field
  // ---------------------------------------------------------------------------
  int    field_lsb  [NUM_FIELDS] = '{OB_DR_WRITE, OB_DR_VALUE, OB_GEN_START, OB_GEN_STOP,
                                     OB_ACK_SET, OB_ACK_CLEAR, OB_BUF_IRQ, OB_RX_VALID,
                                     OB_RX_VALUE, OB_FINISHED, OB_BUSY_RES, OB_WRITE_DONE};
  int    field_w    [NUM_FIELDS] = '{1, 8, 1, 1, 1, 1, 1, 1, 8, 1, 1, 1};
  string field_name [NUM_FIELDS] = '{"dr_write", "dr_value", "gen_start", "gen_stop",
                                     "ack_set", "ack_clear", "buf_irq_enable", "rx_valid",
                                     "rx_value", "finished", "busy_res", "write_done"};

  always @(posedge clk) begin
    logic [OUT_TDATA_W-1:0] want;
    logic [OUT_TDATA_W-1:0] want_f;
    logic [OUT_TDATA_W-1:0] got_f;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_words.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: unexpected item, expected none, got 0x%08h", $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          for (int f = 0; f < NUM_FIELDS; f++) begin
            want_f = (want >> field_lsb[f]) & ((32'd1 << field_w[f]) - 1);
            got_f  = (out_tdata >> field_lsb[f]) & ((32'd1 << field_w[f]) - 1);
            if (want_f !== got_f) begin
              if (mismatches < MAX_REPORTS)
                $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field_name[f],
                         want_f, got_f);
              mismatches++;
            end
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= idle_pct(results_seen, 1'b1));
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build stimulus, release reset, drain, report
  // ---------------------------------------------------------------------------
  initial begin
    item_t      it;
    logic [4:0] wl;
    logic [4:0] rl;

    // Full 16-byte write at the top address; this also fills every store entry,
    // so later sends never hit a byte that was never written.
    it = rand_item(MODE_BEGIN);
    it.dev_addr   = 7'h7F;
    it.send_len   = 5'd16;
    it.recv_len   = 5'd0;
    pending_items.push_back(it);
    for (int i = 0; i < STORE_DEPTH; i++) begin
      it = rand_item(MODE_PUSH);
      if (i == 0) it.data_byte = 8'h00;
      if (i == 1) it.data_byte = 8'hFF;
      pending_items.push_back(it);
    end
    pending_items.push_back(rand_item(MODE_PUSH));   // push past the write length
    it = rand_item(MODE_EVENT);
    {it.flag_rx_ready, it.flag_tx_empty, it.flag_byte_done, it.flag_addr, it.flag_start} = '0;
    pending_items.push_back(it);                      // event with no flag
    it = rand_item(MODE_BEGIN);
    it.dev_addr   = 7'h00;
    it.send_len   = 5'd31;
    it.recv_len   = 5'd31;
    pending_items.push_back(it);                      // begin while busy
    pending_items.push_back(rand_item(MODE_ERROR));   // abort open command
    pending_items.push_back(event_item(EV_START));    // event with no command
    pending_items.push_back(rand_item(MODE_ERROR));   // error with no command
    // read-only command with zero read length: rx-ready ends it at once
    it = rand_item(MODE_BEGIN);
    it.send_len = 5'd0;
    it.recv_len = 5'd0;
    pending_items.push_back(it);
    pending_items.push_back(event_item(EV_RX_READY));
    // byte-finished while reading asks for another repeated start
    it = rand_item(MODE_BEGIN);
    it.send_len = 5'd0;
    it.recv_len = 5'd2;
    pending_items.push_back(it);
    pending_items.push_back(event_item(EV_BYTE_DONE));
    pending_items.push_back(rand_item(MODE_ERROR));

    // Random part: mostly short well-formed commands, a few long or saturating
    while (pending_items.size() < NUM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4))
          pending_items.push_back(rand_item(2'($urandom_range(0, 3))));
        pending_items.push_back(rand_item(MODE_ERROR));
      end
      wl = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 4));
      rl = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 4));
      queue_transfer(wl, rl);
    end
    total_items = pending_items.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_tvalid) @(negedge clk);
    while (expected_words.size() != 0) @(negedge clk);
    // two-stage pipeline; a wait before the report catches stray results
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
